### rtl/ordered_route_table_top_assert.svh
// assertion macros used by the route table top
`ifndef ORDERED_ROUTE_TABLE_TOP_ASSERT_SVH
`define ORDERED_ROUTE_TABLE_TOP_ASSERT_SVH

// condition and consequence in the same cycle
`define ORT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ort_pkg.sv
`default_nettype none

package ort_pkg;

    localparam int ADDR_W  = 32;
    localparam int OCTET_W = 8;

    // request function codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_ADD    = 1'b1;

    // specificity masks
    localparam logic [ADDR_W-1:0] MASK_NONE = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] MASK_OCT3 = 32'hff00_0000;
    localparam logic [ADDR_W-1:0] MASK_OCT2 = 32'hffff_0000;
    localparam logic [ADDR_W-1:0] MASK_ALL  = 32'hffff_ffff;
    localparam logic [OCTET_W-1:0] OCTET_ONES = 8'hff;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_REPLACED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // octet-wise match: at the lowest differing octet the rest of the route must be zero
    function automatic logic net_matches(logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] dst);
        logic hit;
        logic found;
        hit   = 1'b1;
        found = 1'b0;
        for (int k = 0; k < ADDR_W / OCTET_W; k++)
        begin
            if (!found && ((net[OCTET_W*k +: OCTET_W] ^ dst[OCTET_W*k +: OCTET_W]) != '0))
            begin
                found = 1'b1;
                hit   = ((net >> (OCTET_W * k)) == '0);
            end
        end
        return hit;
    endfunction

    // mask from the trailing zero octets of a network
    function automatic logic [ADDR_W-1:0] spec_mask(logic [ADDR_W-1:0] net);
        logic [ADDR_W-1:0] m;
        if ((net & MASK_OCT3) != '0)
            m = MASK_NONE;
        else if ((net[23:16] & OCTET_ONES) != '0)
            m = MASK_OCT3;
        else if ((net[15:8] & OCTET_ONES) != '0)
            m = MASK_OCT2;
        else
            m = MASK_ALL;
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/ort_req_if.sv
`default_nettype none

// request channel: lookup or add route
interface ort_req_if #(
    parameter int DEV_BITS = 4
);
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [ort_pkg::ADDR_W-1:0] addr;
    logic [ort_pkg::ADDR_W-1:0] gateway;
    logic [DEV_BITS-1:0]        dev_index;

    modport source (output valid, output func, output addr, output gateway,
                    output dev_index, input ready);
    modport sink   (input valid, input func, input addr, input gateway,
                    input dev_index, output ready);
endinterface

`default_nettype wire

### rtl/ort_rsp_if.sv
`default_nettype none

// result channel
interface ort_rsp_if #(
    parameter int DEV_BITS = 4
);
    logic                       valid;
    logic                       ready;
    ort_pkg::status_t           status;
    logic [ort_pkg::ADDR_W-1:0] next_hop;
    logic [DEV_BITS-1:0]        out_dev;

    modport source (output valid, output status, output next_hop, output out_dev,
                    input ready);
    modport sink   (input valid, input status, input next_hop, input out_dev,
                    output ready);
endinterface

`default_nettype wire

### rtl/ordered_route_table_top.sv
// Ordered first-match route table. A lookup request scans the entries in table
// order and returns the gateway and device of the first route that matches; an
// add request inserts the new route ahead of the first entry that is no more
// specific (or at the end), moving later entries down, or replaces in place an
// equal network met before that point, and reports full when an insert finds no
// room. One request is in work at a time and req.ready is high only while idle.
// All entries sit in a single ram with one read and one write port; each entry
// moved takes a read state and then a write state. The result sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module ordered_route_table_top #(
    parameter int ROUTE_DEPTH = 16,
    parameter int DEV_BITS    = 4
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ort_req_if.sink    req,
    ort_rsp_if.source  rsp
);

`include "ordered_route_table_top_assert.svh"

    localparam int AW      = $clog2(ROUTE_DEPTH);
    localparam int CW      = $clog2(ROUTE_DEPTH + 1);
    localparam int ENTRY_W = 2 * ort_pkg::ADDR_W + DEV_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       func_reg, func_next;
    logic [ort_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ort_pkg::ADDR_W-1:0] gw_reg, gw_next;
    logic [DEV_BITS-1:0]        dev_reg, dev_next;
    logic [ort_pkg::ADDR_W-1:0] mask_reg, mask_next;
    ort_pkg::status_t           res_status_reg, res_status_next;
    logic [ort_pkg::ADDR_W-1:0] res_hop_reg, res_hop_next;
    logic [DEV_BITS-1:0]        res_dev_reg, res_dev_next;
    logic                       out_valid_reg, out_valid_next;
    ort_pkg::status_t           out_status_reg, out_status_next;
    logic [ort_pkg::ADDR_W-1:0] out_hop_reg, out_hop_next;
    logic [DEV_BITS-1:0]        out_dev_reg, out_dev_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ENTRY_W-1:0]         ram_rdata;

    logic [ort_pkg::ADDR_W-1:0] rd_net;
    logic [ort_pkg::ADDR_W-1:0] rd_gw;
    logic [DEV_BITS-1:0]        rd_dev;
    logic [ENTRY_W-1:0]         new_entry;
    logic [CW-1:0]              idx_inc;
    logic [CW-1:0]              idx_dec;
    logic                       tbl_full;
    logic                       out_free;

    // route storage: {network, gateway, device}
    ort_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROUTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry fields and helpers
    assign rd_net    = ram_rdata[ENTRY_W-1 -: ort_pkg::ADDR_W];
    assign rd_gw     = ram_rdata[DEV_BITS +: ort_pkg::ADDR_W];
    assign rd_dev    = ram_rdata[DEV_BITS-1:0];
    assign new_entry = {addr_reg, gw_reg, dev_reg};
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign tbl_full  = (count_reg == CW'(ROUTE_DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;

    // ports
    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.next_hop = out_hop_reg;
    assign rsp.out_dev  = out_dev_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        addr_next       = addr_reg;
        gw_next         = gw_reg;
        dev_next        = dev_reg;
        mask_next       = mask_reg;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        res_dev_next    = res_dev_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hop_next    = out_hop_reg;
        out_dev_next    = out_dev_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = new_entry;
        ram_raddr       = '0;

        // result taken downstream
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // entry 0 is read while the request is taken
                if (req.valid)
                begin
                    func_next = req.func;
                    addr_next = req.addr;
                    gw_next   = req.gateway;
                    dev_next  = req.dev_index;
                    mask_next = ort_pkg::spec_mask(req.addr);
                    idx_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                ram_raddr = idx_inc[AW-1:0];
                res_hop_next = '0;
                res_dev_next = '0;
                if (idx_reg == count_reg)
                begin
                    // end of table: miss, full, or append
                    if (func_reg == ort_pkg::FUNC_LOOKUP)
                    begin
                        res_status_next = ort_pkg::ST_MISS;
                        state_next      = S_DONE;
                    end
                    else if (tbl_full)
                    begin
                        res_status_next = ort_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        state_next = S_SH_RD;
                    end
                end
                else if (func_reg == ort_pkg::FUNC_LOOKUP)
                begin
                    // first matching route wins
                    if (ort_pkg::net_matches(rd_net, addr_reg))
                    begin
                        res_status_next = ort_pkg::ST_HIT;
                        res_hop_next    = rd_gw;
                        res_dev_next    = rd_dev;
                        state_next      = S_DONE;
                    end
                    else
                        idx_next = idx_inc;
                end
                else if (rd_net == addr_reg)
                begin
                    // equal network, overwrite in place
                    ram_we          = 1'b1;
                    res_status_next = ort_pkg::ST_REPLACED;
                    state_next      = S_DONE;
                end
                else if ((rd_net & mask_reg) == '0)
                begin
                    // insertion point found
                    if (tbl_full)
                    begin
                        res_status_next = ort_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = S_SH_RD;
                    end
                end
                else
                    idx_next = idx_inc;
            end

            S_SH_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    // gap is open, write the new route
                    ram_we          = 1'b1;
                    count_next      = count_reg + CW'(1);
                    res_status_next = ort_pkg::ST_INSERTED;
                    state_next      = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                // move the entry above down by one slot
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hop_next    = res_hop_reg;
                    out_dev_next    = res_dev_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            func_reg       <= ort_pkg::FUNC_LOOKUP;
            addr_reg       <= '0;
            gw_reg         <= '0;
            dev_reg        <= '0;
            mask_reg       <= '0;
            res_status_reg <= ort_pkg::ST_MISS;
            res_hop_reg    <= '0;
            res_dev_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ort_pkg::ST_MISS;
            out_hop_reg    <= '0;
            out_dev_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            func_reg       <= func_next;
            addr_reg       <= addr_next;
            gw_reg         <= gw_next;
            dev_reg        <= dev_next;
            mask_reg       <= mask_next;
            res_status_reg <= res_status_next;
            res_hop_reg    <= res_hop_next;
            res_dev_reg    <= res_dev_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_hop_reg    <= out_hop_next;
            out_dev_reg    <= out_dev_next;
        end
    end

    // checks
    `ORT_ASSERT_SAME(a_count_bound, state_reg == S_IDLE,
        count_reg <= CW'(ROUTE_DEPTH), "route count beyond table depth")
    `ORT_ASSERT_NEXT(a_count_step, state_reg == S_SH_RD && idx_reg == pos_reg,
        count_reg == $past(count_reg) + CW'(1), "insert did not grow the table by one")
    `ORT_ASSERT_SAME(a_shift_above_pos, state_reg == S_SH_WR,
        idx_reg > pos_reg && idx_reg <= count_reg, "entry move outside the open range")
    `ORT_ASSERT_SAME(a_hit_lookup, state_reg == S_DONE && res_status_reg == ort_pkg::ST_HIT,
        func_reg == ort_pkg::FUNC_LOOKUP, "hit reported for an add request")

endmodule

`default_nettype wire

### rtl/ort_ram.sv
`default_nettype none

// simple dual-port ram, one write and one registered read per cycle
module ort_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    import ort_pkg::*;

    localparam int ROUTE_DEPTH    = 16;
    localparam int DEV_BITS       = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   next_hop;
        logic [DEV_BITS-1:0] out_dev;
    } route_result_t;

    logic clk;
    logic rst_n;

    ort_req_if #(.DEV_BITS(DEV_BITS)) req_if ();
    ort_rsp_if #(.DEV_BITS(DEV_BITS)) rsp_if ();

    ordered_route_table_top #(
        .ROUTE_DEPTH (ROUTE_DEPTH),
        .DEV_BITS    (DEV_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // shadow copy of the route table
    logic [ADDR_W-1:0]   tbl_net [ROUTE_DEPTH];
    logic [ADDR_W-1:0]   tbl_gw  [ROUTE_DEPTH];
    logic [DEV_BITS-1:0] tbl_dev [ROUTE_DEPTH];
    int                  tbl_count;

    route_result_t route_results_due[$];
    int            mismatch_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_left;

    always #2 clk = ~clk;

    // a route covers a destination when equal, or when the route is zero from
    // the lowest differing octet upwards
    function automatic bit route_covers(logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] dst);
        logic [ADDR_W-1:0] diff;
        diff = net ^ dst;
        if (diff == '0)
            return 1'b1;
        while (diff[7:0] == '0)
        begin
            diff = diff >> 8;
            net  = net >> 8;
        end
        return net == '0;
    endfunction

    // mask picked by the highest nonzero octet of the new network
    function automatic logic [ADDR_W-1:0] route_mask(logic [ADDR_W-1:0] net);
        if (net[31:24] != '0)
            return MASK_NONE;
        if (net[23:16] != '0)
            return MASK_OCT3;
        if (net[15:8] != '0)
            return MASK_OCT2;
        return MASK_ALL;
    endfunction

    // apply one request to the shadow table and give the result it should produce
    function automatic route_result_t predict_route_result(logic op, logic [ADDR_W-1:0] addr,
            logic [ADDR_W-1:0] gw, logic [DEV_BITS-1:0] dev);
        route_result_t res;
        logic [ADDR_W-1:0] mask;
        int pos;
        bit found;
        res.status   = ST_MISS;
        res.next_hop = '0;
        res.out_dev  = '0;
        found        = 1'b0;
        if (op == FUNC_LOOKUP)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!found && route_covers(tbl_net[i], addr))
                begin
                    found        = 1'b1;
                    res.status   = ST_HIT;
                    res.next_hop = tbl_gw[i];
                    res.out_dev  = tbl_dev[i];
                end
            end
        end
        else
        begin
            mask       = route_mask(addr);
            pos        = tbl_count;
            res.status = ST_INSERTED;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!found)
                begin
                    if (tbl_net[i] == addr)
                    begin
                        res.status = ST_REPLACED;
                        pos        = i;
                        found      = 1'b1;
                    end
                    else if ((tbl_net[i] & mask) == '0)
                    begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
            end
            if (res.status == ST_REPLACED)
            begin
                tbl_gw[pos]  = gw;
                tbl_dev[pos] = dev;
            end
            else if (tbl_count >= ROUTE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                for (int i = tbl_count; i > pos; i--)
                begin
                    tbl_net[i] = tbl_net[i-1];
                    tbl_gw[i]  = tbl_gw[i-1];
                    tbl_dev[i] = tbl_dev[i-1];
                end
                tbl_net[pos] = addr;
                tbl_gw[pos]  = gw;
                tbl_dev[pos] = dev;
                tbl_count++;
            end
        end
        return res;
    endfunction

    // offer one request, wait for it to be taken and log its expected result
    task automatic send_request(logic op, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] gw,
            logic [DEV_BITS-1:0] dev);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= op;
        req_if.addr      <= addr;
        req_if.gateway   <= gw;
        req_if.dev_index <= dev;
        do
            @(posedge clk);
        while (!req_if.ready);
        route_results_due.push_back(predict_route_result(op, addr, gw, dev));
    endtask

    function automatic logic [7:0] random_octet();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return OCTET_ONES;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random device number
    function automatic logic [DEV_BITS-1:0] random_dev();
        return DEV_BITS'($urandom_range(0, 15));
    endfunction

    // network with a random number of leading octets set and the rest zero
    function automatic logic [ADDR_W-1:0] random_network();
        logic [ADDR_W-1:0] net;
        int len;
        net = '0;
        len = $urandom_range(0, 4);
        for (int k = 0; k < len; k++)
            net[8*k +: 8] = random_octet();
        return net;
    endfunction

    // network not present in the table
    function automatic logic [ADDR_W-1:0] fresh_network();
        logic [ADDR_W-1:0] net;
        bit clash;
        do
        begin
            net   = $urandom;
            clash = 1'b0;
            for (int i = 0; i < tbl_count; i++)
                if (tbl_net[i] == net)
                    clash = 1'b1;
        end
        while (clash);
        return net;
    endfunction

    // destination mostly aimed at a stored route
    function automatic logic [ADDR_W-1:0] lookup_target();
        logic [ADDR_W-1:0] dst;
        int top;
        int flip_bit;
        if (tbl_count == 0 || $urandom_range(0, 9) < 3)
            return ($urandom_range(0, 1) == 0) ? $urandom : random_network();
        dst = tbl_net[$urandom_range(0, tbl_count - 1)];
        case ($urandom_range(0, 3))
            0: ;
            1, 2:
            begin
                // fill the zero octets above the route's last significant one
                top = 4;
                while (top > 0 && dst[8*(top-1) +: 8] == '0)
                    top--;
                for (int k = top; k < 4; k++)
                    dst[8*k +: 8] = random_octet();
            end
            default:
            begin
                flip_bit      = $urandom_range(0, ADDR_W - 1);
                dst[flip_bit] = ~dst[flip_bit];
            end
        endcase
        return dst;
    endfunction

    task automatic send_random_request();
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] gw;
        if ($urandom_range(0, 99) < 55)
            send_request(FUNC_LOOKUP, lookup_target(), $urandom, random_dev());
        else
        begin
            if (tbl_count > 0 && $urandom_range(0, 9) < 4)
                net = tbl_net[$urandom_range(0, tbl_count - 1)];
            else
                net = random_network();
            case ($urandom_range(0, 9))
                0: gw = '0;
                1: gw = '1;
                default: gw = $urandom;
            endcase
            send_request(FUNC_ADD, net, gw, random_dev());
        end
    endtask

    // lookups with no routes stored
    task automatic test_empty_table();
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'hffff_ffff, 4'hf);
        send_request(FUNC_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'h0000_000a, 32'h0000_0000, 4'h0);
    endtask

    // adds of each specificity, a replacement and an equal network kept further on
    task automatic test_route_insertion();
        send_request(FUNC_ADD, 32'h0000_000a, 32'hffff_ffff, 4'hf);
        send_request(FUNC_ADD, 32'h0000_0000, 32'h0000_0000, 4'h0);
        send_request(FUNC_ADD, 32'h0000_010a, 32'h0101_0101, 4'h1);
        send_request(FUNC_ADD, 32'h0002_010a, 32'h0202_0202, 4'h2);
        send_request(FUNC_ADD, 32'h0302_010a, 32'h0303_0303, 4'h3);
        send_request(FUNC_ADD, 32'h0402_010a, 32'h0404_0404, 4'h4);
        send_request(FUNC_ADD, 32'h0302_010a, 32'h3333_3333, 4'h5);
        send_request(FUNC_ADD, 32'h0000_000a, 32'h0a0a_0a0a, 4'ha);
        send_request(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
        send_request(FUNC_ADD, 32'h00ff_0000, 32'h0000_0001, 4'h6);
    endtask

    // lookups against the routes above, partial matches and the default route
    task automatic test_route_lookup();
        send_request(FUNC_LOOKUP, 32'h0302_010a, 32'hffff_ffff, 4'hf);
        send_request(FUNC_LOOKUP, 32'h0502_010a, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'h0009_010a, 32'hffff_ffff, 4'hf);
        send_request(FUNC_LOOKUP, 32'h0000_020a, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'h0000_000b, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'h0);
        send_request(FUNC_LOOKUP, 32'h00ff_0001, 32'h0000_0000, 4'h0);
    endtask

    task automatic test_random_traffic(int count);
        repeat (count)
            send_random_request();
    endtask

    // fill every slot, then an add with no room and an add of a stored network while full
    task automatic test_full_table();
        while (tbl_count < ROUTE_DEPTH)
            send_request(FUNC_ADD, fresh_network(), $urandom, random_dev());
        send_request(FUNC_ADD, fresh_network(), $urandom, random_dev());
        send_request(FUNC_ADD, tbl_net[$urandom_range(0, ROUTE_DEPTH - 1)], $urandom,
                     random_dev());
    endtask

    // results held back for a long stretch while requests keep coming
    task automatic test_back_pressure();
        hold_left = HOLD_CYCLES;
        repeat (30)
            send_random_request();
    endtask

    // result side ready, with random gaps and the long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each result with the oldest one due
    always @(posedge clk)
    begin : check_results
        route_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (route_results_due.size() == 0)
            begin
                $display("%0t: status expected none actual %0d", $time, rsp_if.status);
                mismatch_count++;
            end
            else
            begin
                want = route_results_due.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             rsp_if.status);
                    mismatch_count++;
                end
                if (rsp_if.next_hop !== want.next_hop)
                begin
                    $display("%0t: next_hop expected %h actual %h", $time, want.next_hop,
                             rsp_if.next_hop);
                    mismatch_count++;
                end
                if (rsp_if.out_dev !== want.out_dev)
                begin
                    $display("%0t: out_dev expected %0d actual %0d", $time, want.out_dev,
                             rsp_if.out_dev);
                    mismatch_count++;
                end
            end
        end
    end

    // end the run if nothing moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ordered_route_table_top: mismatch");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.func      = FUNC_LOOKUP;
        req_if.addr      = '0;
        req_if.gateway   = '0;
        req_if.dev_index = '0;
        rsp_if.ready     = 1'b0;
        tbl_count        = 0;
        mismatch_count   = 0;
        hold_left        = 0;
        send_idle_pct    = 8;
        recv_idle_pct    = 47;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_route_insertion();
        test_route_lookup();
        test_random_traffic(300);
        test_full_table();

        send_idle_pct = 47;
        recv_idle_pct = 8;
        test_random_traffic(290);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random_traffic(290);

        // drain outstanding results
        req_if.valid <= 1'b0;
        while (route_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("ordered_route_table_top: match");
        else
            $display("ordered_route_table_top: mismatch");
        $finish;
    end

endmodule
